### rtl/bcle_pkg.sv
`default_nettype none

package bcle_pkg;

  localparam int DEF_LIST_DEPTH = 16;

  localparam int CMD_W     = 3;
  localparam int CHAR_W    = 8;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REVERSE = 3'd5;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd6;

  // One result as it leaves the sequencer.
  typedef struct packed {
    logic                 success;
    logic [CHAR_W-1:0]    first_char;
    logic                 first_valid;
    logic [CNT_OUT_W-1:0] entry_count;
  } res_t;

endpackage

`default_nettype wire

### rtl/bounded_char_list_engine_unit.sv
`default_nettype none

// Channel  Direction  Ports                                   Flow control
// input    in         in_valid, in_command, in_char_value     in_stall (driven here)
// result   out        out_valid, out_success, out_first_char,  out_stall (from sink)
//                     out_first_valid, out_entry_count
//
// After an input transfer the result passes the execute and done states on
// its way to the output register; a reverse adds a read state, and a search
// or remove of a nonzero character a scan of the list, with a shift after
// a remove hit, since the single read port of the entry memory delivers
// one entry per cycle and each shifted entry is written back in the cycle
// after its read. The next input transfer can be taken in the cycle after
// the result leaves the sequencer. Reset clears the count, ring head and
// direction; entry contents are never cleared and only live slots are read.
// A result waiting under out_stall does not block the next input transfer,
// but the following result waits in the sequencer until the register frees.

module bounded_char_list_engine_unit #(
  parameter int LIST_DEPTH = bcle_pkg::DEF_LIST_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [bcle_pkg::CMD_W-1:0]     in_command,
  input  wire logic [bcle_pkg::CHAR_W-1:0]    in_char_value,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_success,
  output logic      [bcle_pkg::CHAR_W-1:0]    out_first_char,
  output logic                                out_first_valid,
  output logic      [bcle_pkg::CNT_OUT_W-1:0] out_entry_count
);

  localparam int AW = $clog2(LIST_DEPTH);

  logic                        busy, acc;
  bcle_pkg::res_t              res, out_res_r;
  logic                        res_valid, res_taken;
  logic                        out_valid_r, out_valid_nxt;
  logic                        rd_en, wr_en;
  logic [AW-1:0]               rd_addr, wr_addr;
  logic [bcle_pkg::CHAR_W-1:0] mem_q, wr_data;

  // The sequencer takes one command at a time and stalls while it works.
  assign in_stall = busy;
  assign acc      = in_valid && !busy;

  bcle_mem #(
    .DEPTH (LIST_DEPTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (mem_q),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bcle_seq #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .cmd       (in_command),
    .ch        (in_char_value),
    .busy      (busy),
    .res       (res),
    .res_valid (res_valid),
    .res_taken (res_taken),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .mem_q     (mem_q),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // The output register loads a finished result whenever it is empty or its
  // current contents leave in a transfer this cycle.
  assign res_taken = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (res_taken) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_taken) begin
      out_res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_success     = out_res_r.success;
  assign out_first_char  = out_res_r.first_char;
  assign out_first_valid = out_res_r.first_valid;
  assign out_entry_count = out_res_r.entry_count;

  // An accepted command always keeps the sequencer busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> in_stall)
    else $error("sequencer not busy after an input transfer");

  // An empty list reports a zero first character.
  a_empty_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_first_valid) |-> (out_first_char == '0))
    else $error("empty list reported a nonzero first character");

  // A finished result stays offered until the output register takes it.
  a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_taken) |=> res_valid)
    else $error("finished result dropped before it was taken");

endmodule

`default_nettype wire

### rtl/bcle_mem.sv
`default_nettype none

module bcle_mem #(
  parameter int DEPTH = bcle_pkg::DEF_LIST_DEPTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [AW-1:0]               rd_addr,
  output logic      [bcle_pkg::CHAR_W-1:0] rd_data,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [bcle_pkg::CHAR_W-1:0] wr_data
);

  logic [bcle_pkg::CHAR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### rtl/bcle_seq.sv
`default_nettype none

module bcle_seq #(
  parameter int LIST_DEPTH = bcle_pkg::DEF_LIST_DEPTH,
  localparam int AW = $clog2(LIST_DEPTH),
  localparam int CW = $clog2(LIST_DEPTH + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        acc,
  input  wire logic [bcle_pkg::CMD_W-1:0]  cmd,
  input  wire logic [bcle_pkg::CHAR_W-1:0] ch,
  output logic                             busy,
  output bcle_pkg::res_t                   res,
  output logic                             res_valid,
  input  wire logic                        res_taken,
  output logic                             rd_en,
  output logic      [AW-1:0]               rd_addr,
  input  wire logic [bcle_pkg::CHAR_W-1:0] mem_q,
  output logic                             wr_en,
  output logic      [AW-1:0]               wr_addr,
  output logic      [bcle_pkg::CHAR_W-1:0] wr_data
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EXEC  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_REV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam logic [AW:0]   DEP_W   = (AW+1)'(LIST_DEPTH);
  localparam logic [CW-1:0] CNT_DEP = CW'(LIST_DEPTH);
  localparam logic [AW-1:0] IDX_TOP = AW'(LIST_DEPTH - 1);

  // The list is a ring in the memory: head_r is the slot of the first
  // entry and dir_r the direction in which later entries follow.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] hd, input logic dr,
                                         input logic [AW-1:0] idx);
    logic [AW:0] s;
    if (dr) begin
      s = {1'b0, hd} + DEP_W - {1'b0, idx};
    end else begin
      s = {1'b0, hd} + {1'b0, idx};
    end
    if (s >= DEP_W) begin
      s = s - DEP_W;
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]                  state_r, state_nxt;
  logic [CW-1:0]               count_r, count_nxt;
  logic [AW-1:0]               head_r, head_nxt;
  logic                        dir_r, dir_nxt;
  logic [bcle_pkg::CHAR_W-1:0] first_r, first_nxt;
  logic                        ok_r, ok_nxt;
  logic [bcle_pkg::CMD_W-1:0]  cmd_r;
  logic [bcle_pkg::CHAR_W-1:0] ch_r;
  logic [CW-1:0]               idx_r, idx_nxt;
  logic                        pend_r, pend_nxt;
  logic [AW-1:0]               pidx_r, pidx_nxt;
  logic [CW-1:0]               last_idx;
  logic                        ch_ok, not_full, hit, issue;
  logic [31:0]                 cnt_ext;

  assign ch_ok    = (ch_r != '0);
  assign not_full = (count_r < CNT_DEP);
  assign last_idx = count_r - CW'(1);
  assign hit      = pend_r && (mem_q == ch_r);
  assign issue    = (idx_r < count_r);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    head_nxt  = head_r;
    dir_nxt   = dir_r;
    first_nxt = first_r;
    ok_nxt    = ok_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    pidx_nxt  = pidx_r;
    rd_en     = 1'b0;
    rd_addr   = phys(head_r, dir_r, idx_r[AW-1:0]);
    wr_en     = 1'b0;
    wr_addr   = phys(head_r, dir_r, pidx_r);
    wr_data   = mem_q;
    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_nxt    = 1'b0;
        idx_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = ST_DONE;
        unique case (cmd_r)
          bcle_pkg::CMD_INSERT: begin
            if (ch_ok && not_full) begin
              wr_en     = 1'b1;
              wr_addr   = phys(head_r, dir_r, IDX_TOP);
              wr_data   = ch_r;
              head_nxt  = phys(head_r, dir_r, IDX_TOP);
              count_nxt = count_r + CW'(1);
              first_nxt = ch_r;
              ok_nxt    = 1'b1;
            end
          end
          bcle_pkg::CMD_APPEND: begin
            if (ch_ok && not_full) begin
              wr_en     = 1'b1;
              wr_addr   = phys(head_r, dir_r, count_r[AW-1:0]);
              wr_data   = ch_r;
              count_nxt = count_r + CW'(1);
              if (count_r == '0) begin
                first_nxt = ch_r;
              end
              ok_nxt    = 1'b1;
            end
          end
          bcle_pkg::CMD_REMOVE, bcle_pkg::CMD_SEARCH: begin
            if (ch_ok) begin
              state_nxt = ST_SCAN;
            end
          end
          bcle_pkg::CMD_GET: begin
            ok_nxt = (count_r != '0);
          end
          bcle_pkg::CMD_REVERSE: begin
            ok_nxt = 1'b1;
            if (count_r > CW'(1)) begin
              rd_en     = 1'b1;
              rd_addr   = phys(head_r, dir_r, last_idx[AW-1:0]);
              state_nxt = ST_REV;
            end
          end
          bcle_pkg::CMD_CLEAR: begin
            count_nxt = '0;
            ok_nxt    = 1'b1;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      ST_SCAN: begin
        // One read issued per cycle; each returning entry is compared
        // in the cycle after its read.
        priority if (hit) begin
          if (cmd_r == bcle_pkg::CMD_SEARCH) begin
            ok_nxt    = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            idx_nxt   = CW'(pidx_r) + CW'(1);
            pend_nxt  = 1'b0;
            state_nxt = ST_SHIFT;
          end
        end else if (issue) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0];
          idx_nxt  = idx_r + CW'(1);
        end else begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT: begin
        // Entry k+1 is read, then written to slot k in the next cycle.
        if (pend_r) begin
          wr_en = 1'b1;
          if (pidx_r == '0) begin
            first_nxt = mem_q;
          end
        end
        if (issue) begin
          rd_en    = 1'b1;
          pend_nxt = 1'b1;
          pidx_nxt = idx_r[AW-1:0] - AW'(1);
          idx_nxt  = idx_r + CW'(1);
        end else if (!pend_r) begin
          count_nxt = count_r - CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_REV: begin
        first_nxt = mem_q;
        head_nxt  = phys(head_r, dir_r, last_idx[AW-1:0]);
        dir_nxt   = !dir_r;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_taken) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      head_r  <= '0;
      dir_r   <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      dir_r   <= dir_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    ok_r    <= ok_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    if (acc) begin
      cmd_r <= cmd;
      ch_r  <= ch;
    end
  end

  assign cnt_ext   = 32'(count_r);
  assign busy      = (state_r != ST_IDLE);
  assign res_valid = (state_r == ST_DONE);

  always_comb begin
    res.success     = ok_r;
    res.first_valid = (count_r != '0);
    res.first_char  = (count_r != '0) ? first_r : '0;
    res.entry_count = cnt_ext[bcle_pkg::CNT_OUT_W-1:0];
  end

endmodule

`default_nettype wire

### test/char_list_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the list engine, keeps its own copy of the list,
// and compares every result transfer with the oldest predicted result.
module char_list_checker #(
  parameter int LIST_DEPTH = bcle_pkg::DEF_LIST_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_stall,
  input  wire logic [bcle_pkg::CMD_W-1:0]     in_command,
  input  wire logic [bcle_pkg::CHAR_W-1:0]    in_char_value,
  input  wire logic                           out_valid,
  input  wire logic                           out_stall,
  input  wire logic                           out_success,
  input  wire logic [bcle_pkg::CHAR_W-1:0]    out_first_char,
  input  wire logic                           out_first_valid,
  input  wire logic [bcle_pkg::CNT_OUT_W-1:0] out_entry_count,
  output int unsigned                         pending_results,
  output int unsigned                         mismatch_count
);
  import bcle_pkg::*;

  logic [CHAR_W-1:0] shadow_list [LIST_DEPTH];
  int                shadow_len;
  res_t              expected_results [$];
  int unsigned       error_tally;

  // Applies one command to the shadow list and returns the result it gives.
  function automatic res_t apply_list_command(input logic [CMD_W-1:0]  cmd,
                                              input logic [CHAR_W-1:0] ch);
    res_t              r;
    logic              ok;
    int                hit;
    logic [CHAR_W-1:0] tmp;
    ok  = 1'b0;
    hit = -1;
    for (int i = 0; i < shadow_len; i++) begin
      if (hit < 0 && shadow_list[i] == ch) hit = i;
    end
    case (cmd)
      CMD_INSERT: begin
        if (ch != '0 && shadow_len < LIST_DEPTH) begin
          for (int i = shadow_len; i > 0; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[0] = ch;
          shadow_len++;
          ok = 1'b1;
        end
      end
      CMD_APPEND: begin
        if (ch != '0 && shadow_len < LIST_DEPTH) begin
          shadow_list[shadow_len] = ch;
          shadow_len++;
          ok = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (ch != '0 && hit >= 0) begin
          for (int j = hit; j + 1 < shadow_len; j++) shadow_list[j] = shadow_list[j+1];
          shadow_len--;
          ok = 1'b1;
        end
      end
      CMD_SEARCH: ok = (ch != '0 && hit >= 0);
      CMD_GET:    ok = (shadow_len > 0);
      CMD_REVERSE: begin
        for (int i = 0; i < shadow_len / 2; i++) begin
          tmp = shadow_list[i];
          shadow_list[i] = shadow_list[shadow_len-1-i];
          shadow_list[shadow_len-1-i] = tmp;
        end
        ok = 1'b1;
      end
      CMD_CLEAR: begin
        shadow_len = 0;
        ok = 1'b1;
      end
      default: ok = 1'b0;
    endcase
    r.success     = ok;
    r.first_valid = (shadow_len > 0);
    r.first_char  = (shadow_len > 0) ? shadow_list[0] : '0;
    r.entry_count = CNT_OUT_W'(shadow_len);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      shadow_len  = 0;
      error_tally = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          error_tally++;
        end else begin
          want = expected_results.pop_front();
          if (out_success !== want.success) begin
            $error("out_success: expected %0d, got %0d", want.success, out_success);
            error_tally++;
          end
          if (out_first_char !== want.first_char) begin
            $error("out_first_char: expected %0h, got %0h", want.first_char, out_first_char);
            error_tally++;
          end
          if (out_first_valid !== want.first_valid) begin
            $error("out_first_valid: expected %0d, got %0d", want.first_valid,
                   out_first_valid);
            error_tally++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("out_entry_count: expected %0d, got %0d", want.entry_count,
                   out_entry_count);
            error_tally++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_list_command(in_command, in_char_value));
      end
    end
    pending_results <= expected_results.size();
    mismatch_count  <= error_tally;
  end

endmodule

### test/bounded_char_list_engine_unit_tb.sv
`timescale 1ns / 100ps

// Top of the list engine testbench. It only creates stimulus and stalls and
// gives the verdict; all prediction and comparison lives in the checker.
module bounded_char_list_engine_unit_tb;
  import bcle_pkg::*;

  localparam int DEPTH          = DEF_LIST_DEPTH;
  localparam int RANDOM_ITEMS   = 1630;
  // The slowest command is a remove that walks the full list, and the tail
  // wait covers that with margin.
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 16;
  // A legal quiet stretch is at most a sender gap, a full remove and a sink
  // stall. Anything far beyond is a hang.
  localparam int WATCHDOG_LIMIT = 2000;
  // Code seven is not an operation; the block must answer it as a no-op.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  logic                 clk;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic [CMD_W-1:0]     in_command    = CMD_GET;
  logic [CHAR_W-1:0]    in_char_value = '0;
  logic                 out_stall     = 1'b0;
  logic                 in_stall;
  logic                 out_valid;
  logic                 out_success;
  logic [CHAR_W-1:0]    out_first_char;
  logic                 out_first_valid;
  logic [CNT_OUT_W-1:0] out_entry_count;

  int unsigned pending_results;
  int unsigned mismatch_count;
  int unsigned idle_cycles  = 0;
  int unsigned rx_hold      = 0;
  int unsigned random_sent  = 0;
  bit          tx_quiet     = 1'b0;
  bit          rx_quiet     = 1'b0;

  bounded_char_list_engine_unit #(
    .LIST_DEPTH(DEPTH)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_char_value  (in_char_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_success    (out_success),
    .out_first_char (out_first_char),
    .out_first_valid(out_first_valid),
    .out_entry_count(out_entry_count)
  );

  char_list_checker #(
    .LIST_DEPTH(DEPTH)
  ) list_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_char_value  (in_char_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_success    (out_success),
    .out_first_char (out_first_char),
    .out_first_valid(out_first_valid),
    .out_entry_count(out_entry_count),
    .pending_results(pending_results),
    .mismatch_count (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Presents one command after a random gap and returns at the clock edge
  // where its transfer happens. With no gap, valid simply stays high and
  // only the payload changes, so valid is never dropped and raised in the
  // same time step.
  task automatic send_command(input logic [CMD_W-1:0]  cmd,
                              input logic [CHAR_W-1:0] ch);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_command    <= cmd;
    in_char_value <= ch;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Holds off the sender until every predicted result has come back. The
  // checker registers its count, so the task lets the clock advance first.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // A narrow alphabet makes remove and search hit often and lets duplicates
  // pile up; the wide one sweeps every bit of the character field. Zero
  // turns up now and then in both so the refusal path stays exercised.
  function automatic logic [CHAR_W-1:0] pick_char(input bit narrow);
    if ($urandom_range(0, 19) == 0) return '0;
    if (!narrow) return CHAR_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) return 8'hFF;
    return CHAR_W'($urandom_range(1, 5));
  endfunction

  // One stretch of random traffic. Each stretch picks how strongly it grows
  // the list, so some fill it to the brim and hit the full refusal while
  // others drain it down to empty and exercise misses.
  task automatic run_episode();
    int unsigned      len;
    int unsigned      roll;
    int unsigned      grow_pct;
    bit               narrow;
    logic [CMD_W-1:0] cmd;
    len      = $urandom_range(10, 60);
    narrow   = ($urandom_range(0, 3) != 0);
    grow_pct = $urandom_range(15, 85);
    if ($urandom_range(0, 3) == 0) tx_quiet = !tx_quiet;
    repeat (len) begin
      roll = $urandom_range(0, 99);
      if (roll < grow_pct) begin
        cmd = $urandom_range(0, 1) ? CMD_APPEND : CMD_INSERT;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 35)      cmd = CMD_REMOVE;
        else if (roll < 63) cmd = CMD_SEARCH;
        else if (roll < 78) cmd = CMD_GET;
        else if (roll < 92) cmd = CMD_REVERSE;
        else if (roll < 97) cmd = CMD_CLEAR;
        else                cmd = CMD_UNUSED;
      end
      send_command(cmd, pick_char(narrow));
      random_sent++;
    end
  endtask

  // The sink draws a fresh stall length after every result transfer. Now
  // and then it switches into a quiet mode where it never stalls, so both
  // long runs of back-to-back transfers and heavy back pressure occur.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if ($urandom_range(0, 31) == 0) rx_quiet = !rx_quiet;
      rx_hold = rx_quiet ? 0 : $urandom_range(0, 11);
    end
    out_stall <= (rx_hold != 0);
    if (rx_hold != 0) rx_hold--;
  end

  // The watchdog restarts on every transfer in either direction. A long
  // silence means the block has hung or lost a result.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Everything on an empty list: nothing to read, find, or remove, and a
    // reverse that has to leave it alone.
    send_command(CMD_GET, 8'h41);
    send_command(CMD_REVERSE, 8'h00);
    send_command(CMD_REMOVE, 8'h41);
    send_command(CMD_SEARCH, 8'h41);
    // Append to an empty list, then reverse a list of one.
    send_command(CMD_APPEND, 8'h01);
    send_command(CMD_REVERSE, 8'hFF);
    // The zero character is refused by every command that takes one.
    send_command(CMD_INSERT, 8'h00);
    send_command(CMD_APPEND, 8'h00);
    send_command(CMD_REMOVE, 8'h00);
    send_command(CMD_SEARCH, 8'h00);
    // Build a short list from both ends and probe it.
    send_command(CMD_INSERT, 8'hFF);
    send_command(CMD_INSERT, 8'h80);
    send_command(CMD_APPEND, 8'h7F);
    send_command(CMD_SEARCH, 8'h7F);
    send_command(CMD_SEARCH, 8'h55);
    send_command(CMD_REMOVE, 8'hFF);
    send_command(CMD_REVERSE, 8'h00);
    send_command(CMD_GET, 8'hAA);
    send_command(CMD_UNUSED, 8'h80);
    send_command(CMD_REMOVE, 8'h7F);
    send_command(CMD_CLEAR, 8'h01);
    send_command(CMD_GET, 8'h00);

    // Let the directed part fully drain before random traffic starts.
    wait_for_drain();

    while (random_sent < RANDOM_ITEMS) begin
      run_episode();
      if ($urandom_range(0, 15) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
